>>> hdl/qkcd_pkg.sv
// Package for the quadrature knob counter and display core.
// Holds the shared widths, codes, tables and transaction structs; no dependencies.
package qkcd_pkg;

  localparam int unsigned ENC_W   = 4;   // two phase pairs
  localparam int unsigned BTN_W   = 3;   // raw button levels on the port
  localparam int unsigned COUNT_W = 10;  // displayed count width
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned SCAN_W  = 3;
  localparam int unsigned DET_W   = 8;

  // Debounce: the history is 12 bits per button, newest sample in bit 0.
  // A press is "released once, then eleven lows" in history plus a low sample now.
  localparam int unsigned         HIST_W        = 12;
  localparam logic [HIST_W-1:0]   PRESS_PATTERN = 12'h800;

  // Detent window: 2..9 counts up, above 0xF0 counts down.
  localparam logic [DET_W-1:0] DET_INC_LO  = 8'd2;
  localparam logic [DET_W-1:0] DET_INC_HI  = 8'd9;
  localparam logic [DET_W-1:0] DET_DEC_MIN = 8'hF0;
  localparam logic [1:0]       PHASE_REST  = 2'b11;

  // Reciprocals for constant division of values below 10000.
  localparam int unsigned RECIP_W       = 14;
  localparam int unsigned RECIP_10      = 6554;
  localparam int unsigned RECIP_10_SH   = 16;
  localparam int unsigned RECIP_100     = 5243;
  localparam int unsigned RECIP_100_SH  = 19;
  localparam int unsigned RECIP_1000    = 8389;
  localparam int unsigned RECIP_1000_SH = 23;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

  // Step codes
  localparam logic [STEP_W-1:0] STEP_NONE = 3'd1;
  localparam logic [STEP_W-1:0] STEP_A    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_B    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_AB   = 3'd0;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  localparam dir_e DIR_TABLE [16] = '{
    DIR_HOLD, DIR_UP,   DIR_DOWN, DIR_HOLD,
    DIR_DOWN, DIR_HOLD, DIR_HOLD, DIR_UP,
    DIR_UP,   DIR_HOLD, DIR_HOLD, DIR_DOWN,
    DIR_HOLD, DIR_DOWN, DIR_UP,   DIR_HOLD
  };

  typedef enum logic [SCAN_W-1:0] {
    SCAN_ONES      = 3'd0,
    SCAN_TENS      = 3'd1,
    SCAN_COLON     = 3'd2,
    SCAN_HUNDREDS  = 3'd3,
    SCAN_THOUSANDS = 3'd4
  } scan_pos_e;

  // Detent decision of one knob for the current transaction.
  typedef struct packed {
    logic inc;
    logic dec;
  } knob_step_t;

  typedef struct packed {
    logic [SEG_W-1:0] ones;
    logic [SEG_W-1:0] tens;
    logic [SEG_W-1:0] hundreds;
    logic [SEG_W-1:0] thousands;
    logic [SEG_W-1:0] scan;
  } disp_t;

  // Active-low segment code; digits above nine give all zeros.
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

>>> hdl/qkcd_if.sv
// Valid/ready channel interfaces for the knob counter core.
// Depends on qkcd_pkg for payload widths.
interface qkcd_in_if import qkcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ENC_W-1:0] encoder_bits;
  logic [BTN_W-1:0] buttons_raw;

  modport source (output valid, output encoder_bits, output buttons_raw, input ready);
  modport sink   (input valid, input encoder_bits, input buttons_raw, output ready);
endinterface

interface qkcd_out_if import qkcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count_value;
  logic [SEG_W-1:0]   ones_code;
  logic [SEG_W-1:0]   tens_code;
  logic [SEG_W-1:0]   hundreds_code;
  logic [SEG_W-1:0]   thousands_code;
  logic [SCAN_W-1:0]  scan_position;
  logic [SEG_W-1:0]   scan_code;
  logic               mode_a_flag;
  logic               mode_b_flag;
  logic [STEP_W-1:0]  step_size;

  modport source (
    output valid, output count_value, output ones_code, output tens_code,
    output hundreds_code, output thousands_code, output scan_position,
    output scan_code, output mode_a_flag, output mode_b_flag, output step_size,
    input ready
  );
  modport sink (
    input valid, input count_value, input ones_code, input tens_code,
    input hundreds_code, input thousands_code, input scan_position,
    input scan_code, input mode_a_flag, input mode_b_flag, input step_size,
    output ready
  );
endinterface

>>> hdl/qkcd_knob.sv
// One quadrature knob: phase transition decode and detent counter.
// Depends on qkcd_pkg for the direction table and detent window.
module qkcd_knob import qkcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [1:0] phase_i,
  output knob_step_t step_o
);

  logic [1:0]       prev_q;
  logic [DET_W-1:0] cnt_q, cnt_d, cnt_new;
  dir_e             dir;

  always_comb begin
    dir    = DIR_TABLE[{prev_q, phase_i}];
    step_o = '0;
    case (dir)
      DIR_UP:   cnt_new = cnt_q + 1'b1;
      DIR_DOWN: cnt_new = cnt_q - 1'b1;
      default:  cnt_new = cnt_q;
    endcase
    cnt_d = cnt_new;
    if (phase_i == PHASE_REST) begin
      if (cnt_new inside {[DET_INC_LO:DET_INC_HI]}) begin
        step_o.inc = 1'b1;
      end else if (cnt_new > DET_DEC_MIN) begin
        step_o.dec = 1'b1;
      end
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cnt_q  <= '0;
    end else if (en_i) begin
      prev_q <= phase_i;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> hdl/qkcd_digits.sv
// BCD split and seven-segment encode of the counter, plus scan selection.
// Depends on qkcd_pkg; divides by 10, 100 and 1000 through reciprocal products.
module qkcd_digits import qkcd_pkg::*; #(
  parameter int unsigned VAL_W = 11
) (
  input  logic [VAL_W-1:0] value_i,
  input  scan_pos_e        pos_i,
  output disp_t            disp_o
);

  localparam int unsigned PW = VAL_W + RECIP_W;

  logic [PW-1:0]    val_w, prod10, prod100, prod1000;
  logic [PW-1:0]    sh10, sh100, sh1000;
  logic [VAL_W-1:0] q10, q100, q1000;
  logic [VAL_W-1:0] r1, r10, r100;

  always_comb begin
    val_w    = PW'(value_i);
    prod10   = val_w * PW'(RECIP_10);
    prod100  = val_w * PW'(RECIP_100);
    prod1000 = val_w * PW'(RECIP_1000);
    sh10     = prod10 >> RECIP_10_SH;
    sh100    = prod100 >> RECIP_100_SH;
    sh1000   = prod1000 >> RECIP_1000_SH;
    q10      = sh10[VAL_W-1:0];
    q100     = sh100[VAL_W-1:0];
    q1000    = sh1000[VAL_W-1:0];
    // remainder digit = quotient - 10 * next quotient
    r1       = value_i - (q10 << 3) - (q10 << 1);
    r10      = q10 - (q100 << 3) - (q100 << 1);
    r100     = q100 - (q1000 << 3) - (q1000 << 1);

    disp_o.ones      = seg_code(r1[3:0]);
    disp_o.tens      = (val_w < PW'(10))   ? SEG_BLANK : seg_code(r10[3:0]);
    disp_o.hundreds  = (val_w < PW'(100))  ? SEG_BLANK : seg_code(r100[3:0]);
    disp_o.thousands = (val_w < PW'(1000)) ? SEG_BLANK :
                       ((q1000 > VAL_W'(9)) ? 8'h00 : seg_code(q1000[3:0]));

    case (pos_i)
      SCAN_ONES:      disp_o.scan = disp_o.ones;
      SCAN_TENS:      disp_o.scan = disp_o.tens;
      SCAN_HUNDREDS:  disp_o.scan = disp_o.hundreds;
      SCAN_THOUSANDS: disp_o.scan = disp_o.thousands;
      default:        disp_o.scan = SEG_BLANK;
    endcase
  end

endmodule

>>> hdl/quadrature_knob_counter_display_core.sv
// Top level of the two-knob quadrature counter with seven-segment display.
// Depends on qkcd_pkg, qkcd_if, qkcd_knob and qkcd_digits.

// The core takes transactions (encoder phases and raw button levels) and
// returns exactly one result transaction for each. Sustained rate is one
// transaction per cycle while out_o.ready stays high. The accepting edge
// updates the knob decoders, the wrapped counter, the debounce histories, the
// mode bits and the scan index; when that stage moves on, the output register
// loads the BCD segment codes, the scanned digit and the flags. The counter
// loop (add both knob steps, wrap) closes through counter_q alone, which is
// what fixes the one-per-cycle rate. in_i.ready stays high while the output
// register holds an untaken result, as long as the middle stage is empty;
// once both stages hold a transaction, in_i.ready follows out_o.ready.
// Knob steps use the step size as it stood before the same transaction's
// buttons. All other block state is in flip-flops cleared by rst_ni; no clearing
// pass. The output data register is not reset and only counts when valid.
module quadrature_knob_counter_display_core import qkcd_pkg::*; #(
  parameter int unsigned VALUE_MAX    = 1023,
  parameter int unsigned BUTTON_TOTAL = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  qkcd_in_if.sink    in_i,
  qkcd_out_if.source out_o
);

  // Counter holds 0..VALUE_MAX, the raw sum reaches VALUE_MAX + 8.
  localparam int unsigned CNT_W = $clog2(VALUE_MAX + 9);
  localparam int unsigned SUM_W = CNT_W + 2;
  localparam int unsigned EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic signed [SUM_W-1:0] VMAX_S = SUM_W'(VALUE_MAX);

  // ---------------------------------------------------------------------
  // Handshake: stage 1 is the state registers, stage 2 the output register
  // ---------------------------------------------------------------------
  logic in_acc, s1_move;
  logic s1_valid_q, out_valid_q;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Knobs: bits 3:2 left, bits 1:0 right
  // ---------------------------------------------------------------------
  knob_step_t left_step, right_step;

  qkcd_knob u_knob_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_acc),
    .phase_i (in_i.encoder_bits[3:2]),
    .step_o  (left_step)
  );

  qkcd_knob u_knob_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_acc),
    .phase_i (in_i.encoder_bits[1:0]),
    .step_o  (right_step)
  );

  // ---------------------------------------------------------------------
  // Counter update and wrap
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]        counter_q, counter_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic signed [SUM_W-1:0] step_s, d_left, d_right, total;

  always_comb begin
    step_s  = $signed({{(SUM_W-STEP_W){1'b0}}, step_q});
    d_left  = left_step.inc  ? step_s : (left_step.dec  ? -step_s : '0);
    d_right = right_step.inc ? step_s : (right_step.dec ? -step_s : '0);
    total   = $signed({2'b00, counter_q}) + d_left + d_right;
    if (total < 0) begin
      // underflow lands at VALUE_MAX - step + 1
      counter_d = (step_q != '0) ? CNT_W'(VALUE_MAX) - CNT_W'(step_q) + 1'b1
                                 : CNT_W'(VALUE_MAX);
    end else if (total > VMAX_S) begin
      counter_d = CNT_W'(total - VMAX_S);
    end else begin
      counter_d = CNT_W'(total);
    end
  end

  // ---------------------------------------------------------------------
  // Scan index: position used by this transaction, index points one past
  // ---------------------------------------------------------------------
  logic [SCAN_W-1:0] scan_idx_q, scan_pos_in, scan_pos_s1;

  assign scan_pos_in = (scan_idx_q > SCAN_THOUSANDS) ? SCAN_ONES : scan_idx_q;
  assign scan_pos_s1 = scan_idx_q - 1'b1;

  // ---------------------------------------------------------------------
  // Button debounce, mode toggles and step choice
  // ---------------------------------------------------------------------
  logic [HIST_W-1:0]             hist_q [BUTTON_TOTAL];
  logic [BUTTON_TOTAL+BTN_W-1:0] lvl_pad;
  logic [BUTTON_TOTAL-1:0]       press;
  logic                          mode_a_q, mode_b_q, mode_a_d, mode_b_d;

  // buttons beyond the port read as released
  assign lvl_pad = {{BUTTON_TOTAL{1'b1}}, in_i.buttons_raw};

  always_comb begin
    for (int n = 0; n < BUTTON_TOTAL; n++) begin
      press[n] = (hist_q[n] == PRESS_PATTERN) && !lvl_pad[n];
    end
    mode_a_d = mode_a_q ^ press[0];
    mode_b_d = mode_b_q ^ press[1];
    step_d   = step_q;
    if (|press) begin
      if (mode_a_d && mode_b_d) begin
        step_d = STEP_AB;
      end else if (mode_a_d) begin
        step_d = STEP_A;
      end else if (mode_b_d) begin
        step_d = STEP_B;
      end else begin
        step_d = STEP_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q  <= '0;
      step_q     <= STEP_NONE;
      mode_a_q   <= 1'b0;
      mode_b_q   <= 1'b0;
      scan_idx_q <= '0;
      for (int n = 0; n < BUTTON_TOTAL; n++) begin
        hist_q[n] <= '0;
      end
    end else if (in_acc) begin
      counter_q  <= counter_d;
      step_q     <= step_d;
      mode_a_q   <= mode_a_d;
      mode_b_q   <= mode_b_d;
      scan_idx_q <= scan_pos_in + 1'b1;
      for (int n = 0; n < BUTTON_TOTAL; n++) begin
        hist_q[n] <= {hist_q[n][HIST_W-2:0], lvl_pad[n]};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Display decode into the output register
  // ---------------------------------------------------------------------
  disp_t            disp;
  disp_t            disp_q;
  logic [EXT_W-1:0] count_ext;
  logic [COUNT_W-1:0] count_q;
  logic [SCAN_W-1:0]  pos_q;
  logic               mode_a_o_q, mode_b_o_q;
  logic [STEP_W-1:0]  step_o_q;

  qkcd_digits #(
    .VAL_W (CNT_W)
  ) u_digits (
    .value_i (counter_q),
    .pos_i   (scan_pos_e'(scan_pos_s1)),
    .disp_o  (disp)
  );

  assign count_ext = EXT_W'(counter_q);

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      disp_q     <= disp;
      count_q    <= count_ext[COUNT_W-1:0];
      pos_q      <= scan_pos_s1;
      mode_a_o_q <= mode_a_q;
      mode_b_o_q <= mode_b_q;
      step_o_q   <= step_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.count_value    = count_q;
  assign out_o.ones_code      = disp_q.ones;
  assign out_o.tens_code      = disp_q.tens;
  assign out_o.hundreds_code  = disp_q.hundreds;
  assign out_o.thousands_code = disp_q.thousands;
  assign out_o.scan_position  = pos_q;
  assign out_o.scan_code      = disp_q.scan;
  assign out_o.mode_a_flag    = mode_a_o_q;
  assign out_o.mode_b_flag    = mode_b_o_q;
  assign out_o.step_size      = step_o_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_counter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counter_q <= CNT_W'(VALUE_MAX))
    else $error("counter left its wrap range");

  a_step_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(step_q))
    else $error("step size is not 0, 1, 2 or 4");

  a_scan_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (scan_idx_q != '0 && scan_idx_q <= 3'd5))
    else $error("scan index out of step with pending transaction");

  a_move_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("result lost moving into output register");

endmodule
